/* design/dpa_pkg.sv */
// Shared types, constants and pair arithmetic for the int8 dot-product accumulator.
package dpa_pkg;

  localparam int LANES          = 8;
  localparam int BYTES_PER_LANE = 4;
  localparam int ACC_W          = 32;
  localparam int PAIR_W         = 16;
  localparam int HALF_LANES     = LANES / 2;

  typedef struct packed {
    logic advance;
    logic take;
    logic s1_valid;
    logic s1_last;
  } lane_ctl_t;

  typedef struct packed {
    logic advance;
    logic s2_valid;
  } merge_ctl_t;

  // Two unsigned-by-signed byte products, added and saturated to signed 16 bits.
  function automatic logic signed [PAIR_W-1:0] pair_sum(
    input logic [7:0] u0,
    input logic [7:0] u1,
    input logic [7:0] s0,
    input logic [7:0] s1
  );
    logic signed [16:0] p0;
    logic signed [16:0] p1;
    logic signed [17:0] sum;
    logic signed [PAIR_W-1:0] res;
    p0  = $signed({1'b0, u0}) * $signed(s0);
    p1  = $signed({1'b0, u1}) * $signed(s1);
    sum = 18'(p0) + 18'(p1);
    if (sum > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = sum[PAIR_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/dpa_lane.sv */
// One lane: four byte products, two saturated pair sums and a wrapping 32-bit accumulator.
module dpa_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  dpa_pkg::lane_ctl_t            ctl,
  input  logic [31:0]                   ubytes,
  input  logic [31:0]                   sbytes,
  output logic [dpa_pkg::ACC_W-1:0]     lane_total
);
  import dpa_pkg::*;

  logic signed [PAIR_W-1:0] pair_lo;
  logic signed [PAIR_W-1:0] pair_hi;
  logic signed [PAIR_W:0]   contrib;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_next;

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.take) begin
      pair_lo <= pair_sum(ubytes[7:0], ubytes[15:8], sbytes[7:0], sbytes[15:8]);
      pair_hi <= pair_sum(ubytes[23:16], ubytes[31:24], sbytes[23:16], sbytes[31:24]);
    end
  end

  assign contrib  = (PAIR_W+1)'(pair_lo) + (PAIR_W+1)'(pair_hi);
  assign acc_next = acc + ACC_W'(contrib);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.advance && ctl.s1_valid) begin
      acc <= ctl.s1_last ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.s1_valid && ctl.s1_last) begin
      lane_total <= acc_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (ctl.advance && ctl.s1_valid && ctl.s1_last) |=> (acc == '0))
    else $error("lane accumulator not cleared after the last word");

  a_hold_when_frozen: assert property (@(posedge clk) disable iff (rst)
    !ctl.advance |=> $stable(acc))
    else $error("lane accumulator changed while the pipeline was frozen");

  a_hold_when_empty: assert property (@(posedge clk) disable iff (rst)
    !ctl.s1_valid |=> $stable(acc))
    else $error("lane accumulator changed without a word in the multiply stage");

endmodule

/* design/dpa_merge.sv */
// Registered adder tree that merges the lane totals and holds the output word.
module dpa_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  dpa_pkg::merge_ctl_t           ctl,
  input  logic [dpa_pkg::ACC_W-1:0]     lane_totals [dpa_pkg::LANES],
  output logic                          total_valid,
  output logic signed [dpa_pkg::ACC_W-1:0] dot_total
);
  import dpa_pkg::*;

  logic             s3_valid;
  logic [ACC_W-1:0] partials [HALF_LANES];
  logic [ACC_W-1:0] total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid    <= 1'b0;
      total_valid <= 1'b0;
    end else if (ctl.advance) begin
      s3_valid    <= ctl.s2_valid;
      total_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.s2_valid) begin
      for (int i = 0; i < HALF_LANES; i++) begin
        partials[i] <= lane_totals[2*i] + lane_totals[2*i+1];
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int i = 0; i < HALF_LANES; i++) begin
      total_next = total_next + partials[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && s3_valid) begin
      dot_total <= $signed(total_next);
    end
  end

endmodule

/* design/u8_s8_dot_product_accumulator.sv */
// Top level of the u8 x s8 dot-product accumulator with eight parallel lanes.
// A last-flagged word's total passes the pair, lane-total, partial and output registers.
// Throughput: one input word per cycle; the whole pipeline freezes only while the output
// word is held by a stalled receiver. Reset clears the lane accumulators and all valid flags.
module u8_s8_dot_product_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        chunk_valid,
  output logic        chunk_stall,
  input  logic [63:0] unsigned_bytes_lo,
  input  logic [63:0] unsigned_bytes_mid_lo,
  input  logic [63:0] unsigned_bytes_mid_hi,
  input  logic [63:0] unsigned_bytes_hi,
  input  logic [63:0] signed_bytes_lo,
  input  logic [63:0] signed_bytes_mid_lo,
  input  logic [63:0] signed_bytes_mid_hi,
  input  logic [63:0] signed_bytes_hi,
  input  logic        final_chunk,
  output logic        total_valid,
  input  logic        total_stall,
  output logic signed [31:0] dot_total
);
  import dpa_pkg::*;

  logic             advance;
  logic             s1_valid;
  logic             s1_last;
  logic             s2_valid;
  logic [255:0]     all_u;
  logic [255:0]     all_s;
  lane_ctl_t        lane_ctl;
  merge_ctl_t       merge_ctl;
  logic [ACC_W-1:0] lane_totals [LANES];

  assign advance     = !(total_valid && total_stall);
  assign chunk_stall = !advance;

  assign all_u = {unsigned_bytes_hi, unsigned_bytes_mid_hi,
                  unsigned_bytes_mid_lo, unsigned_bytes_lo};
  assign all_s = {signed_bytes_hi, signed_bytes_mid_hi,
                  signed_bytes_mid_lo, signed_bytes_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= chunk_valid;
      s1_last  <= final_chunk;
      s2_valid <= s1_valid && s1_last;
    end
  end

  assign lane_ctl.advance  = advance;
  assign lane_ctl.take     = chunk_valid;
  assign lane_ctl.s1_valid = s1_valid;
  assign lane_ctl.s1_last  = s1_last;

  assign merge_ctl.advance  = advance;
  assign merge_ctl.s2_valid = s2_valid;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    dpa_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (lane_ctl),
      .ubytes     (all_u[BYTES_PER_LANE*8*j +: BYTES_PER_LANE*8]),
      .sbytes     (all_s[BYTES_PER_LANE*8*j +: BYTES_PER_LANE*8]),
      .lane_total (lane_totals[j])
    );
  end

  dpa_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (merge_ctl),
    .lane_totals (lane_totals),
    .total_valid (total_valid),
    .dot_total   (dot_total)
  );

endmodule
